// ----- rtl/core/binary_min_heap_queue_defines.svh -----
// Assertion macros used by the checker file of the heap queue.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BMHQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bmhq_pkg.sv -----
// Shared types, codes and constants of the binary min-heap queue.
package bmhq_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int LIMIT_W      = 9;
    localparam int HANDLE_W     = 9;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 9;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Read address selection for the two heap RAM read ports.
    localparam logic [1:0] RD_REM = 2'd0; // root and last entry
    localparam logic [1:0] RD_UP  = 2'd1; // parent of the hole
    localparam logic [1:0] RD_DN  = 2'd2; // both children of the hole

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } entry_t;

    typedef struct packed {
        logic                accept;
        logic                ins_start;
        logic                rem_start;
        logic                dn_load;
        logic                wr_entry;
        logic                up_move;
        logic                dn_move;
        logic                out_load;
        logic [1:0]          rd_sel;
        logic [STATUS_W-1:0] status_val;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic cnt_zero;
        logic left_out;
        logic up_less;
        logic dn_stop;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/core/bmhq_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module bmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- rtl/core/bmhq_ctrl.sv -----
// Sequencer of the heap queue: steps insert and remove through the datapath.
module bmhq_ctrl import bmhq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic mode,
    input  sts_t sts,
    output logic in_stall,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_LOAD = 3'd3;
    localparam logic [2:0] S_DN_RD   = 3'd4;
    localparam logic [2:0] S_DN_CMP  = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_REM;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept     = 1'b1;
                    cmd.status_val = ST_OK;
                    if (mode == MODE_INSERT)
                    begin
                        if (sts.full)
                        begin
                            cmd.status_val = ST_FULL;
                            state_next     = S_FIN;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (sts.empty)
                        begin
                            cmd.status_val = ST_EMPTY;
                            state_next     = S_FIN;
                        end
                        else
                        begin
                            cmd.rem_start = 1'b1;
                            state_next    = S_DN_LOAD;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (sts.pos_zero)
                begin
                    cmd.wr_entry = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.rd_sel = RD_UP;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.up_less)
                begin
                    cmd.up_move = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    cmd.wr_entry = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_DN_LOAD:
            begin
                cmd.dn_load = 1'b1;
                state_next  = sts.cnt_zero ? S_FIN : S_DN_RD;
            end
            S_DN_RD:
            begin
                if (sts.left_out)
                begin
                    cmd.wr_entry = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.rd_sel = RD_DN;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (sts.dn_stop)
                begin
                    cmd.wr_entry = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_RD;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/bmhq_dpath.sv -----
// Datapath of the heap queue: heap RAM, hole position, moving entry, result beat.
module bmhq_dpath import bmhq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LIMIT_W-1:0]     cfg_wr_data,
    input  logic [HANDLE_W-1:0]    node_handle,
    input  logic [KEY_W-1:0]       key_freq,
    input  logic                   out_stall,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    output logic [STATUS_W-1:0]    status,
    output logic [HANDLE_W-1:0]    out_handle,
    output logic [KEY_W-1:0]       out_key,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = ADDR_W + 1;
    localparam int LW     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    logic [LIMIT_W-1:0]     limit_reg,     limit_next;
    logic [CNT_W-1:0]       count_reg,     count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]      pos_reg,       pos_next;
    entry_t                 ent_reg,       ent_next;
    entry_t                 res_reg,       res_next;
    logic [STATUS_W-1:0]    stat_reg,      stat_next;
    logic [STATUS_W-1:0]    out_stat_reg,  out_stat_next;
    entry_t                 out_res_reg,   out_res_next;
    logic [COUNT_OUT_W-1:0] out_cnt_reg,   out_cnt_next;

    logic [LW-1:0]     lim_ext;
    logic [LW-1:0]     cap_lw;
    logic [LW-1:0]     eff_limit;
    logic [ADDR_W-1:0] parent;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
    logic [IDX_W-1:0]  cnt_idx;
    logic [ADDR_W-1:0] last_addr;
    logic              right_ok;
    logic              pick_right;
    entry_t            pick_ent;
    logic [ADDR_W-1:0] pick_addr;

    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    entry_t            rd_a;
    entry_t            rd_b;
    logic              wr_en;
    entry_t            wr_data;

    // Clamp the limit to the heap depth.
    assign lim_ext   = LW'(limit_reg);
    assign cap_lw    = LW'(CAPACITY);
    assign eff_limit = (lim_ext > cap_lw) ? cap_lw : lim_ext;

    assign parent    = (pos_reg - ADDR_W'(1)) >> 1;
    assign left      = {pos_reg, 1'b1};
    assign right     = left + IDX_W'(1);
    assign cnt_idx   = IDX_W'(count_reg);
    assign last_addr = ADDR_W'(count_reg - CNT_W'(1));

    // Right child only when present and strictly smaller.
    assign right_ok   = (right < cnt_idx);
    assign pick_right = right_ok && (rd_b.key < rd_a.key);
    assign pick_ent   = pick_right ? rd_b : rd_a;
    assign pick_addr  = pick_right ? ADDR_W'(right) : ADDR_W'(left);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_UP:
            begin
                rd_addr_a = parent;
                rd_addr_b = last_addr;
            end
            RD_DN:
            begin
                rd_addr_a = ADDR_W'(left);
                rd_addr_b = ADDR_W'(right);
            end
            default:
            begin
                rd_addr_a = '0;
                rd_addr_b = last_addr;
            end
        endcase
    end

    assign wr_en = cmd.wr_entry | cmd.up_move | cmd.dn_move;

    always_comb
    begin
        priority if (cmd.up_move)
        begin
            wr_data = rd_a;
        end
        else if (cmd.dn_move)
        begin
            wr_data = pick_ent;
        end
        else
        begin
            wr_data = ent_reg;
        end
    end

    bmhq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (pos_reg),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_b)
    );

    assign sts.full     = (LW'(count_reg) >= eff_limit);
    assign sts.empty    = (count_reg == '0);
    assign sts.pos_zero = (pos_reg == '0);
    assign sts.cnt_zero = (count_reg == '0);
    assign sts.left_out = (left >= cnt_idx);
    assign sts.up_less  = (ent_reg.key < rd_a.key);
    // Stop on no greater than the chosen child; both compares run in parallel.
    assign sts.dn_stop  = pick_right ? (ent_reg.key <= rd_b.key) : (ent_reg.key <= rd_a.key);
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        limit_next     = cfg_wr_en ? cfg_wr_data : limit_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        ent_next       = ent_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_res_next   = out_res_reg;
        out_cnt_next   = out_cnt_reg;

        if (cmd.accept)
        begin
            res_next  = '0;
            stat_next = cmd.status_val;
        end
        if (cmd.ins_start)
        begin
            count_next = count_reg + CNT_W'(1);
            pos_next   = ADDR_W'(count_reg);
            ent_next   = '{handle: node_handle, key: key_freq};
        end
        if (cmd.rem_start)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.dn_load)
        begin
            res_next = rd_a;
            ent_next = rd_b;
            pos_next = '0;
        end
        if (cmd.up_move)
        begin
            pos_next = parent;
        end
        if (cmd.dn_move)
        begin
            pos_next = pick_addr;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_stat_next  = stat_reg;
            out_res_next   = res_reg;
            out_cnt_next   = COUNT_OUT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        ent_reg      <= ent_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        out_stat_reg <= out_stat_next;
        out_res_reg  <= out_res_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_stat_reg;
    assign out_handle  = out_res_reg.handle;
    assign out_key     = out_res_reg.key;
    assign entry_count = out_cnt_reg;

endmodule

// ----- rtl/core/binary_min_heap_queue.sv -----
// Top level of the binary min-heap priority queue of (handle, key) entries.
//
// A priority queue of (node_handle, key_freq) entries kept as a binary
// min-heap in one RAM of CAPACITY entries; the smallest key is served first.
// mode 0 inserts an entry, mode 1 removes the minimum, and every input beat
// gives exactly one result beat carrying status, the removed entry (zero
// unless a remove succeeded) and the entry count after the operation.
// Items are worked one at a time: in_stall rises for the whole operation.
// Each heap level takes a RAM read step and a compare/write step on the
// two-read, one-write heap RAM; a remove that takes the only entry skips
// the walk down, and refused inserts and removes on an empty heap go
// straight to the result step. A finished result sits in an output
// register, so the next item is taken while it waits; a result that finds
// the output still occupied holds until it is taken. capacity_limit
// (reset 256, values above CAPACITY act as CAPACITY, 0 refuses every insert)
// is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce. The
// RAM is not cleared: only entries below the count are ever used.
module binary_min_heap_queue import bmhq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LIMIT_W-1:0]     cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic [HANDLE_W-1:0]    node_handle,
    input  logic [KEY_W-1:0]       key_freq,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [HANDLE_W-1:0]    out_handle,
    output logic [KEY_W-1:0]       out_key,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    // Commands from the sequencer, status back from the datapath.
    cmd_t cmd;
    sts_t sts;

    // Sequencer: decide insert/refuse/remove/empty at the input beat, then
    // walk the hole up or down one level per read/compare pair.
    bmhq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Datapath: heap RAM, count and limit, moving entry held in a register
    // so that each level writes only the entry that takes the hole.
    bmhq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .node_handle (node_handle),
        .key_freq    (key_freq),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .status      (status),
        .out_handle  (out_handle),
        .out_key     (out_key),
        .entry_count (entry_count)
    );

endmodule

// ----- rtl/core/bmhq_checker.sv -----
// Port-level assertions of the heap queue and their bind to the top level.
`include "binary_min_heap_queue_defines.svh"

module bmhq_checker import bmhq_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [STATUS_W-1:0]    status,
    input logic [HANDLE_W-1:0]    out_handle,
    input logic [KEY_W-1:0]       out_key,
    input logic [COUNT_OUT_W-1:0] entry_count
);

    `BMHQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(out_handle) && $stable(out_key) && $stable(entry_count), "stalled result beat changed")
    `BMHQ_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "input taken while an item is in flight")
    `BMHQ_ASSERT_NOW(a_empty_res, out_valid && status == ST_EMPTY, entry_count == '0 && out_handle == '0 && out_key == '0, "empty status with entries or data")
    `BMHQ_ASSERT_NOW(a_full_res, out_valid && status == ST_FULL, out_handle == '0 && out_key == '0, "refused insert carries data")

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (.*);

// ----- tb/binary_min_heap_queue_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the heap queue: predicts each result beat and compares it.
module binary_min_heap_queue_checker import bmhq_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LIMIT_W-1:0]     cfg_wr_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   mode,
    input  logic [HANDLE_W-1:0]    node_handle,
    input  logic [KEY_W-1:0]       key_freq,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [STATUS_W-1:0]    status,
    input  logic [HANDLE_W-1:0]    out_handle,
    input  logic [KEY_W-1:0]       out_key,
    input  logic [COUNT_OUT_W-1:0] entry_count,
    output int                     mismatches,
    output int                     pending
);

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [HANDLE_W-1:0]    handle;
        logic [KEY_W-1:0]       key;
        logic [COUNT_OUT_W-1:0] count;
    } heap_result_t;

    logic [KEY_W-1:0]    heap_key [CAPACITY_DEF];
    logic [HANDLE_W-1:0] heap_hdl [CAPACITY_DEF];
    int unsigned         shadow_fill;
    int unsigned         limit_reg;
    heap_result_t        due_results [$];

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        logic [KEY_W-1:0]    k;
        logic [HANDLE_W-1:0] h;
        k           = heap_key[a];
        h           = heap_hdl[a];
        heap_key[a] = heap_key[b];
        heap_hdl[a] = heap_hdl[b];
        heap_key[b] = k;
        heap_hdl[b] = h;
    endfunction

    // Apply one operation to the shadow heap and return the result it gives.
    function automatic heap_result_t heap_apply(input logic op,
                                                input logic [HANDLE_W-1:0] h,
                                                input logic [KEY_W-1:0] k);
        heap_result_t r;
        int unsigned  lim;
        int unsigned  pos;
        int unsigned  parent;
        int unsigned  left;
        int unsigned  right;
        int unsigned  pick;
        bit           done;
        r    = '0;
        done = 1'b0;
        lim  = (limit_reg > CAPACITY_DEF) ? CAPACITY_DEF : limit_reg;
        if (op == MODE_INSERT) begin
            if (shadow_fill >= lim) begin
                r.status = ST_FULL;
            end else begin
                heap_key[shadow_fill] = k;
                heap_hdl[shadow_fill] = h;
                pos = shadow_fill;
                shadow_fill++;
                // Ties stay put on the way up.
                while (pos > 0 && !done) begin
                    parent = (pos - 1) / 2;
                    if (heap_key[pos] < heap_key[parent]) begin
                        swap_slots(pos, parent);
                        pos = parent;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end else if (shadow_fill == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status = ST_OK;
            r.handle = heap_hdl[0];
            r.key    = heap_key[0];
            shadow_fill--;
            if (shadow_fill > 0) begin
                heap_key[0] = heap_key[shadow_fill];
                heap_hdl[0] = heap_hdl[shadow_fill];
                pos = 0;
                // Right child wins only when strictly smaller; stop on a tie.
                while (!done) begin
                    left  = 2 * pos + 1;
                    right = left + 1;
                    if (left >= shadow_fill) begin
                        done = 1'b1;
                    end else begin
                        pick = left;
                        if (right < shadow_fill && heap_key[right] < heap_key[left])
                            pick = right;
                        if (heap_key[pos] <= heap_key[pick]) begin
                            done = 1'b1;
                        end else begin
                            swap_slots(pos, pick);
                            pos = pick;
                        end
                    end
                end
            end
        end
        r.count = shadow_fill[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] seen);
        if (seen !== want) begin
            mismatches++;
            $error("%s expected %0d actual %0d", name, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        heap_result_t want;
        if (!rst_n) begin
            shadow_fill = 0;
            limit_reg   = 32'(LIMIT_RESET);
            mismatches  = 0;
            due_results.delete();
        end else begin
            // Retire first: a result never belongs to the item taken at the same edge.
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $error("result beat with no expectation waiting");
                end else begin
                    want = due_results.pop_front();
                    check_field("status", KEY_W'(want.status), KEY_W'(status));
                    check_field("out_handle", KEY_W'(want.handle), KEY_W'(out_handle));
                    check_field("out_key", want.key, out_key);
                    check_field("entry_count", KEY_W'(want.count), KEY_W'(entry_count));
                end
            end
            // A beat taken at this edge still sees the old limit.
            if (in_valid && !in_stall)
                due_results.push_back(heap_apply(mode, node_handle, key_freq));
            if (cfg_wr_en)
                limit_reg = 32'(cfg_wr_data);
        end
        pending = due_results.size();
    end

endmodule

// ----- tb/binary_min_heap_queue_tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the binary min-heap queue.
module binary_min_heap_queue_tb;
    import bmhq_pkg::*;

    // Slowest correct run: ~1100 beats, each with the longest heap walk plus
    // sender gaps and receiver stalls; the limit allows ten times that.
    localparam int CYCLE_LIMIT = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [LIMIT_W-1:0]     cfg_wr_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   mode;
    logic [HANDLE_W-1:0]    node_handle;
    logic [KEY_W-1:0]       key_freq;
    logic                   out_valid;
    logic                   out_stall;
    logic [STATUS_W-1:0]    status;
    logic [HANDLE_W-1:0]    out_handle;
    logic [KEY_W-1:0]       out_key;
    logic [COUNT_OUT_W-1:0] entry_count;

    int mismatches;
    int pending;

    // Idle knobs: chance per beat of a sender gap, chance per cycle of a
    // receiver stall burst, and a switch that turns both off for the tail.
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          quiet;
    int unsigned stall_run;
    int unsigned cycle_count;

    int unsigned inserts_sent;
    int unsigned removes_sent;
    int unsigned settings_used;

    binary_min_heap_queue uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .node_handle (node_handle),
        .key_freq    (key_freq),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_handle  (out_handle),
        .out_key     (out_key),
        .entry_count (entry_count)
    );

    binary_min_heap_queue_checker heap_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .node_handle (node_handle),
        .key_freq    (key_freq),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_handle  (out_handle),
        .out_key     (out_key),
        .entry_count (entry_count),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Receiver side: stall in bursts of random length, never while quiet.
    always @(posedge clk)
    begin
        if (quiet || !rst_n) begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 6);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Keys lean on the extremes and on a narrow band so ties are frequent.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Present one beat and hold it until the block takes it. Called at a
    // rising edge; returns at the edge of acceptance with valid still high,
    // so back-to-back beats never drop valid.
    task automatic send_beat(input logic op, input logic [HANDLE_W-1:0] h,
                             input logic [KEY_W-1:0] k);
        if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        node_handle <= h;
        key_freq    <= k;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (op == MODE_INSERT)
            inserts_sent++;
        else
            removes_sent++;
    endtask

    // Drop valid and hold off until every expected result is back. The first
    // edge lets the scoreboard log the last beat before its count is trusted.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the capacity register with the block idle.
    task automatic set_limit(input logic [LIMIT_W-1:0] lim);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // One random phase: a limit, a beat count and an insert bias, so that
    // some phases fill the heap to its limit and others drain it.
    task automatic random_phase(input logic [LIMIT_W-1:0] lim, input int unsigned beats,
                                input int unsigned insert_pct, input int unsigned idle_pct);
        logic op;
        set_limit(lim);
        gap_pct   = idle_pct;
        stall_pct = idle_pct;
        repeat (beats)
        begin
            op = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
            send_beat(op, HANDLE_W'($urandom_range(0, 511)), pick_key());
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        in_valid      <= 1'b0;
        mode          <= MODE_INSERT;
        node_handle   <= '0;
        key_freq      <= '0;
        out_stall     <= 1'b0;
        stall_run     <= 0;
        cycle_count   <= 0;
        gap_pct       = 20;
        stall_pct     = 20;
        quiet         = 1'b0;
        inserts_sent  = 0;
        removes_sent  = 0;
        settings_used = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero limit refuses an insert; a remove on the empty heap.
        set_limit(9'd0);
        send_beat(MODE_INSERT, 9'h1FF, 32'hFFFF_FFFF);
        send_beat(MODE_REMOVE, 9'h1FF, 32'hFFFF_FFFF);

        // Limit of one: fill, refuse, remove the single entry, then empty.
        set_limit(9'd1);
        send_beat(MODE_INSERT, 9'd0, 32'd0);
        send_beat(MODE_INSERT, 9'd1, 32'd1);
        send_beat(MODE_REMOVE, 9'h1FF, 32'hFFFF_FFFF);
        send_beat(MODE_REMOVE, 9'd0, 32'd0);

        // Limit above the array size acts as the array size; equal keys
        // must not move past each other.
        set_limit(9'h1FF);
        send_beat(MODE_INSERT, 9'h1FF, 32'hFFFF_FFFF);
        send_beat(MODE_INSERT, 9'd7, 32'd5);
        send_beat(MODE_INSERT, 9'd8, 32'd5);
        send_beat(MODE_INSERT, 9'd9, 32'd5);
        send_beat(MODE_INSERT, 9'd10, 32'd0);
        send_beat(MODE_INSERT, 9'd11, 32'h8000_0000);
        send_beat(MODE_INSERT, 9'd12, 32'd5);
        send_beat(MODE_REMOVE, 9'd0, 32'd0);
        send_beat(MODE_REMOVE, 9'd0, 32'd0);

        // Limit lowered below the count: inserts refused, removes still work.
        set_limit(9'd2);
        send_beat(MODE_INSERT, 9'd13, 32'd1);
        send_beat(MODE_REMOVE, 9'd0, 32'd0);
        send_beat(MODE_REMOVE, 9'd0, 32'd0);
        send_beat(MODE_REMOVE, 9'd0, 32'd0);
        send_beat(MODE_INSERT, 9'd14, 32'd2);
        send_beat(MODE_REMOVE, 9'd0, 32'd0);
        send_beat(MODE_INSERT, 9'd15, 32'd3);

        // Random phases. Fill the full array first, then lower the limit far
        // below the count, drain with a remove-heavy phase, and walk the small limits.
        random_phase(9'd256, 330, 90, 20);
        random_phase(9'd8, 100, 50, 35);
        random_phase(9'h1FF, 250, 20, 10);
        random_phase(9'd1, 60, 50, 0);
        random_phase(9'd0, 30, 50, 25);
        random_phase(LIMIT_W'($urandom_range(2, 40)), 150, 55, 15);

        // Tail: no idling on either side.
        wait_drained();
        quiet = 1'b1;
        random_phase(9'd256, 100, 50, 0);

        wait_drained();
        repeat (30) @(posedge clk);

        $display("Covered %0d inserts and %0d removes over %0d capacity settings,",
                 inserts_sent, removes_sent, settings_used);
        $display("from zero and one up to beyond the array size, full and empty included.");
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
